@@ design/rfp_pkg.sv @@
// Shared types and constants for the ranging frame parser.
`default_nettype none

package rfp_pkg;

    // Frame layout: sync byte, header, eight distance bytes, checksum.
    localparam int FRAME_LENGTH = 13;
    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [3:0] FIRST_DIST_POS = 4'd4;
    localparam logic [3:0] LAST_DIST_POS = 4'd11;
    localparam logic [3:0] CHECK_POS = 4'(FRAME_LENGTH - 1);
    localparam int DIST_BYTES = 8;
    localparam int DIST_IDX_W = $clog2(DIST_BYTES);

    // Parser state: waiting for sync, or inside a frame.
    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_FRAME = 1'b1
    } t_state;

    // One result transaction: four big-endian distances.
    typedef struct packed {
        logic [15:0] distance_one;
        logic [15:0] distance_two;
        logic [15:0] distance_three;
        logic [15:0] distance_four;
    } t_result;

endpackage

`default_nettype wire

@@ design/rfp_frame_fsm.sv @@
// Frame tracking, running checksum and distance byte storage.
`default_nettype none

module rfp_frame_fsm (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_rx_byte,
    output logic                o_push,
    output rfp_pkg::t_result    o_result
);

    rfp_pkg::t_state r_state, n_state;
    logic [3:0] r_byte_count, n_byte_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_dist [rfp_pkg::DIST_BYTES];

    logic       dist_write;
    logic [3:0] dist_offset;
    logic [rfp_pkg::DIST_IDX_W-1:0] dist_idx;

    // Distance bytes sit at frame positions four to eleven.
    assign dist_offset = r_byte_count - rfp_pkg::FIRST_DIST_POS;
    assign dist_idx    = dist_offset[rfp_pkg::DIST_IDX_W-1:0];
    assign dist_write  = i_accept && (r_state == rfp_pkg::ST_FRAME)
                      && (r_byte_count >= rfp_pkg::FIRST_DIST_POS)
                      && (r_byte_count <= rfp_pkg::LAST_DIST_POS);

    // Stored bytes form the result; byte pairs are high byte first.
    assign o_result.distance_one   = {r_dist[0], r_dist[1]};
    assign o_result.distance_two   = {r_dist[2], r_dist[3]};
    assign o_result.distance_three = {r_dist[4], r_dist[5]};
    assign o_result.distance_four  = {r_dist[6], r_dist[7]};

    // State register with count and sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rfp_pkg::ST_IDLE;
            r_byte_count <= 4'd0;
            r_sum        <= 8'd0;
        end else begin
            r_state      <= n_state;
            r_byte_count <= n_byte_count;
            r_sum        <= n_sum;
        end
    end

    // Distance byte storage needs no reset; every frame fills it first.
    always_ff @(posedge i_clk) begin
        if (dist_write) begin
            r_dist[dist_idx] <= i_rx_byte;
        end
    end

    // Next state, count, sum and the result push.
    always_comb begin
        n_state      = r_state;
        n_byte_count = r_byte_count;
        n_sum        = r_sum;
        o_push       = 1'b0;
        unique case (r_state)
            rfp_pkg::ST_IDLE: begin
                if (i_accept && (i_rx_byte == rfp_pkg::SYNC_BYTE)) begin
                    n_state      = rfp_pkg::ST_FRAME;
                    n_byte_count = 4'd1;
                    n_sum        = i_rx_byte;
                end
            end
            rfp_pkg::ST_FRAME: begin
                if (i_accept) begin
                    if (r_byte_count >= rfp_pkg::CHECK_POS) begin
                        // Checksum byte: emit on match, return to idle either way.
                        o_push       = (i_rx_byte == r_sum);
                        n_state      = rfp_pkg::ST_IDLE;
                        n_byte_count = 4'd0;
                        n_sum        = 8'd0;
                    end else begin
                        n_sum        = r_sum + i_rx_byte;
                        n_byte_count = r_byte_count + 4'd1;
                    end
                end
            end
            default: begin
                n_state = rfp_pkg::ST_IDLE;
            end
        endcase
    end

    // While idle, the count and the sum are clear.
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rfp_pkg::ST_IDLE) |-> (r_byte_count == 4'd0 && r_sum == 8'd0))
        else $error("idle with nonzero count or sum");

    // Inside a frame the count stays between one and the checksum position.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rfp_pkg::ST_FRAME)
            |-> (r_byte_count >= 4'd1 && r_byte_count <= rfp_pkg::CHECK_POS))
        else $error("byte count out of range in frame");

    // A result always ends the frame.
    a_push_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_state == rfp_pkg::ST_IDLE))
        else $error("frame still open after result");

endmodule

`default_nettype wire

@@ design/rfp_result_buf.sv @@
// Two-entry result buffer: output register plus skid register.
`default_nettype none

module rfp_result_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire rfp_pkg::t_result i_result,
    input  wire logic             i_stall,
    output logic                  o_valid,
    output rfp_pkg::t_result      o_result,
    output logic                  o_full
);

    logic             r_out_valid, r_skid_valid;
    rfp_pkg::t_result r_out, r_skid;
    logic             pop;

    assign pop      = r_out_valid && !i_stall;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign o_full   = r_skid_valid;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid) begin
            r_out_valid  <= i_push;
        end else if (pop) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= r_skid_valid && i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid) begin
            r_out <= i_result;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    // The skid entry is only used behind a full output register.
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds data while output is empty");

    // A push into a stalled full output lands in the skid register.
    a_push_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_out_valid && !pop) |=> r_skid_valid)
        else $error("result lost on stalled output");

    // Draining the last entry with no push leaves the buffer empty.
    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !r_skid_valid && !i_push) |=> !r_out_valid)
        else $error("result repeated after drain");

endmodule

`default_nettype wire

@@ design/ranging_frame_parser.sv @@
// Top level of the ranging frame parser: byte framing and result output.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+----------------------------------
//  input   | in        | i_valid / o_stall    | i_rx_byte[7:0]
//  result  | out       | o_valid / i_stall    | o_distance_one .. o_distance_four
//
// One byte is taken per cycle while o_stall is low; framing state updates at the
// edge that accepts it. A good checksum byte yields a result transaction that is
// registered in the output register, or in the skid one behind a busy output.
// Reset is synchronous and active low; it returns the parser to idle and empties
// the result buffer. A result waiting on i_stall does not stop input; o_stall
// rises only when a second result is held in the skid register.
`default_nettype none

module ranging_frame_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_distance_one,
    output logic [15:0]      o_distance_two,
    output logic [15:0]      o_distance_three,
    output logic [15:0]      o_distance_four
);

    logic             accept;
    logic             push;
    logic             full;
    rfp_pkg::t_result frame_result;
    rfp_pkg::t_result out_result;

    // Input transaction accepted whenever the buffer has room.
    assign o_stall = full;
    assign accept  = i_valid && !full;

    rfp_frame_fsm u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (push),
        .o_result  (frame_result)
    );

    rfp_result_buf u_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (frame_result),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (out_result),
        .o_full   (full)
    );

    // Result fields out to their own ports.
    assign o_distance_one   = out_result.distance_one;
    assign o_distance_two   = out_result.distance_two;
    assign o_distance_three = out_result.distance_three;
    assign o_distance_four  = out_result.distance_four;

endmodule

`default_nettype wire
